// ===== design/nfes_pkg.sv =====
// Package for the NOR-flash-like byte store: field widths, function and
// status codes, result kinds and the command/status structs between the
// controller and the datapath. Depends on nothing.
package nfes_pkg;

    localparam int FUNC_W   = 2;
    localparam int OFFSET_W = 12;
    localparam int LENGTH_W = 7;
    localparam int BYTE_W   = 8;
    localparam int STATUS_W = 2;
    localparam int SIZE_W   = 13;
    localparam int CFG_IDX_W = 1;

    localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_WRITE = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_ERASE = 2'd2;

    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FLASH = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SIZE  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_CHECK = 1'b1;

    localparam logic [SIZE_W-1:0] SIZE_RESET_VAL = 13'd4096;
    localparam logic [BYTE_W-1:0] ERASED_BYTE    = 8'hFF;

    // Kind of result loaded into the output register.
    localparam logic [1:0] OUT_READ  = 2'd0;
    localparam logic [1:0] OUT_OK    = 2'd1;
    localparam logic [1:0] OUT_RANGE = 2'd2;
    localparam logic [1:0] OUT_WRITE = 2'd3;

    typedef struct packed {
        logic       take_item;
        logic       clr_write;
        logic       rd_issue;
        logic       cnt_inc;
        logic       erase_write;
        logic       wr_read_req;
        logic       wr_step;
        logic       wr_start;
        logic       out_load;
        logic [1:0] out_kind;
    } cmd_t;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic              len_zero;
        logic              in_range;
        logic              wr_pending;
        logic              wr_final;
        logic              cnt_last;
        logic              clr_done;
        logic              out_free;
    } sts_t;

endpackage

// ===== design/nfes_ctrl.sv =====
// Controller state machine of the NOR-flash-like byte store.
// Depends on nfes_pkg for the command and status structs and the codes.
module nfes_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  nfes_pkg::sts_t sts,
    output nfes_pkg::cmd_t cmd
);

    localparam logic [2:0] ST_CLEAR  = 3'd0;
    localparam logic [2:0] ST_IDLE   = 3'd1;
    localparam logic [2:0] ST_DECODE = 3'd2;
    localparam logic [2:0] ST_READ   = 3'd3;
    localparam logic [2:0] ST_RDATA  = 3'd4;
    localparam logic [2:0] ST_ERASE  = 3'd5;
    localparam logic [2:0] ST_WCHECK = 3'd6;
    localparam logic [2:0] ST_RESP   = 3'd7;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic [1:0] resp_kind_reg;
    logic [1:0] resp_kind_next;

    assign in_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        cmd            = '0;
        state_next     = state_reg;
        resp_kind_next = resp_kind_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.clr_write = 1'b1;
                if (sts.clr_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.take_item = 1'b1;
                    state_next    = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                case (sts.func)
                    nfes_pkg::FUNC_READ, nfes_pkg::FUNC_ERASE:
                    begin
                        if (!sts.in_range)
                        begin
                            resp_kind_next = nfes_pkg::OUT_RANGE;
                            state_next     = ST_RESP;
                        end
                        else if (sts.len_zero)
                        begin
                            resp_kind_next = nfes_pkg::OUT_OK;
                            state_next     = ST_RESP;
                        end
                        else if (sts.func == nfes_pkg::FUNC_READ)
                        begin
                            state_next = ST_READ;
                        end
                        else
                        begin
                            state_next = ST_ERASE;
                        end
                    end
                    nfes_pkg::FUNC_WRITE:
                    begin
                        if (sts.wr_pending)
                        begin
                            cmd.wr_read_req = 1'b1;
                            state_next      = ST_WCHECK;
                        end
                        else if (!sts.in_range)
                        begin
                            resp_kind_next = nfes_pkg::OUT_RANGE;
                            state_next     = ST_RESP;
                        end
                        else if (sts.len_zero)
                        begin
                            resp_kind_next = nfes_pkg::OUT_OK;
                            state_next     = ST_RESP;
                        end
                        else
                        begin
                            cmd.wr_start = 1'b1;
                            state_next   = ST_IDLE;
                        end
                    end
                    default:
                    begin
                        state_next = ST_IDLE;
                    end
                endcase
            end
            ST_READ:
            begin
                cmd.rd_issue = 1'b1;
                state_next   = ST_RDATA;
            end
            ST_RDATA:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    cmd.out_kind = nfes_pkg::OUT_READ;
                    cmd.cnt_inc  = 1'b1;
                    state_next   = sts.cnt_last ? ST_IDLE : ST_READ;
                end
            end
            ST_ERASE:
            begin
                cmd.erase_write = 1'b1;
                if (sts.cnt_last)
                begin
                    resp_kind_next = nfes_pkg::OUT_OK;
                    state_next     = ST_RESP;
                end
            end
            ST_WCHECK:
            begin
                cmd.wr_step = 1'b1;
                if (sts.wr_final)
                begin
                    resp_kind_next = nfes_pkg::OUT_WRITE;
                    state_next     = ST_RESP;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_RESP:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    cmd.out_kind = resp_kind_reg;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            resp_kind_reg <= nfes_pkg::OUT_OK;
        end
        else
        begin
            state_reg     <= state_next;
            resp_kind_reg <= resp_kind_next;
        end
    end

`ifndef SYNTHESIS
    a_load_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> sts.out_free)
        else $error("Result loaded while the output register is still full.");

    a_step_after_read: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.wr_step |-> $past(cmd.wr_read_req))
        else $error("Write step without the stored byte having been read.");

    a_start_only_header: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.wr_start |-> !sts.wr_pending)
        else $error("Write header taken while a write is still pending.");

    a_last_read_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.out_load && (cmd.out_kind == nfes_pkg::OUT_READ) && sts.cnt_last)
        |=> in_ready)
        else $error("Read did not finish after its final byte.");
`endif

endmodule

// ===== design/nfes_dpath.sv =====
// Datapath of the NOR-flash-like byte store: item registers, range check,
// configuration, write tracking, the byte memory and the output register.
// Depends on nfes_pkg for widths, codes and the command/status structs.
module nfes_dpath #(
    parameter int MEM_BYTES = 4096,
    parameter int MAX_BURST = 64
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  nfes_pkg::cmd_t                   cmd,
    output nfes_pkg::sts_t                   sts,
    input  logic [nfes_pkg::FUNC_W-1:0]      func,
    input  logic [nfes_pkg::OFFSET_W-1:0]    offset,
    input  logic [nfes_pkg::LENGTH_W-1:0]    length,
    input  logic [nfes_pkg::BYTE_W-1:0]      data_byte,
    input  logic                             cfg_fire,
    input  logic [nfes_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [nfes_pkg::SIZE_W-1:0]      cfg_data,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [nfes_pkg::STATUS_W-1:0]    status,
    output logic [nfes_pkg::BYTE_W-1:0]      read_byte,
    output logic [nfes_pkg::OFFSET_W-1:0]    fault_address,
    output logic                             last
);

    localparam int AW = $clog2(MEM_BYTES);
    localparam logic [nfes_pkg::SIZE_W-1:0] SIZE_RESET =
        (32'(nfes_pkg::SIZE_RESET_VAL) < MEM_BYTES) ? nfes_pkg::SIZE_RESET_VAL
                                                    : nfes_pkg::SIZE_W'(MEM_BYTES);
    localparam logic [nfes_pkg::LENGTH_W-1:0] BURST_MAX = nfes_pkg::LENGTH_W'(MAX_BURST);
    localparam logic [AW-1:0] LAST_ADDR = AW'(MEM_BYTES - 1);

    // Item registers.
    logic [nfes_pkg::FUNC_W-1:0]   func_reg,   func_next;
    logic [nfes_pkg::OFFSET_W-1:0] off_reg,    off_next;
    logic [nfes_pkg::LENGTH_W-1:0] len_reg,    len_next;
    logic [nfes_pkg::BYTE_W-1:0]   db_reg,     db_next;
    logic [nfes_pkg::LENGTH_W-1:0] cnt_reg,    cnt_next;

    // Configuration.
    logic [nfes_pkg::SIZE_W-1:0]   size_reg,   size_next;
    logic                          check_reg,  check_next;

    // Pending write.
    logic [nfes_pkg::LENGTH_W-1:0] wleft_reg,  wleft_next;
    logic [nfes_pkg::OFFSET_W-1:0] waddr_reg,  waddr_next;
    logic                          wabort_reg, wabort_next;
    logic [nfes_pkg::OFFSET_W-1:0] wfault_reg, wfault_next;

    logic [AW-1:0]                 clr_reg,    clr_next;

    // Output register.
    logic                          ovalid_reg, ovalid_next;
    logic [nfes_pkg::STATUS_W-1:0] ostat_reg,  ostat_next;
    logic [nfes_pkg::BYTE_W-1:0]   obyte_reg,  obyte_next;
    logic [nfes_pkg::OFFSET_W-1:0] ofault_reg, ofault_next;
    logic                          olast_reg,  olast_next;

    // Memory.
    logic [nfes_pkg::BYTE_W-1:0]   byte_store_mem [MEM_BYTES];
    logic [nfes_pkg::BYTE_W-1:0]   rdata_reg;
    logic [AW-1:0]                 mem_addr;
    logic                          mem_we;
    logic                          mem_re;
    logic [nfes_pkg::BYTE_W-1:0]   mem_wdata;

    logic [nfes_pkg::SIZE_W-1:0]   end_addr;
    logic [nfes_pkg::SIZE_W-1:0]   burst_addr;
    logic                          violation;
    logic                          out_free;
    logic [nfes_pkg::SIZE_W-1:0]   size_cfg;

    assign end_addr   = {1'b0, off_reg} + nfes_pkg::SIZE_W'(len_reg);
    assign burst_addr = {1'b0, off_reg} + nfes_pkg::SIZE_W'(cnt_reg);
    assign violation  = check_reg && ((db_reg & rdata_reg) != db_reg);
    assign out_free   = !ovalid_reg || out_ready;
    assign size_cfg   = (32'(cfg_data) < MEM_BYTES) ? cfg_data
                                                    : nfes_pkg::SIZE_W'(MEM_BYTES);

    assign sts.func       = func_reg;
    assign sts.len_zero   = (len_reg == '0);
    assign sts.in_range   = (end_addr <= size_reg) && (len_reg <= BURST_MAX);
    assign sts.wr_pending = (wleft_reg != '0);
    assign sts.wr_final   = (wleft_reg == nfes_pkg::LENGTH_W'(1));
    assign sts.cnt_last   = (nfes_pkg::LENGTH_W'(cnt_reg + 1'b1) == len_reg);
    assign sts.clr_done   = (clr_reg == LAST_ADDR);
    assign sts.out_free   = out_free;

    // One port: the sweep, the write tracker or the burst counter drives it.
    always_comb
    begin
        if (cmd.clr_write)
        begin
            mem_addr = clr_reg;
        end
        else if (cmd.wr_read_req || cmd.wr_step)
        begin
            mem_addr = AW'(waddr_reg);
        end
        else
        begin
            mem_addr = AW'(burst_addr);
        end
        mem_re    = cmd.rd_issue || cmd.wr_read_req;
        mem_we    = cmd.clr_write || cmd.erase_write ||
                    (cmd.wr_step && !wabort_reg && !violation);
        mem_wdata = cmd.wr_step ? db_reg : nfes_pkg::ERASED_BYTE;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            byte_store_mem[mem_addr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rdata_reg <= byte_store_mem[mem_addr];
        end
    end

    always_comb
    begin
        func_next   = func_reg;
        off_next    = off_reg;
        len_next    = len_reg;
        db_next     = db_reg;
        cnt_next    = cnt_reg;
        size_next   = size_reg;
        check_next  = check_reg;
        wleft_next  = wleft_reg;
        waddr_next  = waddr_reg;
        wabort_next = wabort_reg;
        wfault_next = wfault_reg;
        clr_next    = clr_reg;

        if (cmd.take_item)
        begin
            func_next = func;
            off_next  = offset;
            len_next  = length;
            db_next   = data_byte;
            cnt_next  = '0;
        end
        if (cmd.cnt_inc || cmd.erase_write)
        begin
            cnt_next = nfes_pkg::LENGTH_W'(cnt_reg + 1'b1);
        end
        if (cmd.clr_write)
        begin
            clr_next = AW'(clr_reg + 1'b1);
        end
        if (cfg_fire)
        begin
            case (cfg_index)
                nfes_pkg::CFG_IDX_SIZE:  size_next  = size_cfg;
                nfes_pkg::CFG_IDX_CHECK: check_next = cfg_data[0];
                default:                 size_next  = size_reg;
            endcase
        end
        if (cmd.wr_start)
        begin
            wleft_next  = len_reg;
            waddr_next  = off_reg;
            wabort_next = 1'b0;
            wfault_next = '0;
        end
        if (cmd.wr_step)
        begin
            wleft_next = nfes_pkg::LENGTH_W'(wleft_reg - 1'b1);
            waddr_next = nfes_pkg::OFFSET_W'(waddr_reg + 1'b1);
            if (!wabort_reg && violation)
            begin
                wabort_next = 1'b1;
                wfault_next = waddr_reg;
            end
        end
    end

    always_comb
    begin
        ostat_next  = ostat_reg;
        obyte_next  = obyte_reg;
        ofault_next = ofault_reg;
        olast_next  = olast_reg;
        if (cmd.out_load)
        begin
            ovalid_next = 1'b1;
        end
        else if (out_ready)
        begin
            ovalid_next = 1'b0;
        end
        else
        begin
            ovalid_next = ovalid_reg;
        end
        if (cmd.out_load)
        begin
            obyte_next  = '0;
            ofault_next = '0;
            olast_next  = 1'b1;
            case (cmd.out_kind)
                nfes_pkg::OUT_READ:
                begin
                    ostat_next = nfes_pkg::STATUS_OK;
                    obyte_next = rdata_reg;
                    olast_next = sts.cnt_last;
                end
                nfes_pkg::OUT_OK:
                begin
                    ostat_next = nfes_pkg::STATUS_OK;
                end
                nfes_pkg::OUT_RANGE:
                begin
                    ostat_next = nfes_pkg::STATUS_RANGE;
                end
                nfes_pkg::OUT_WRITE:
                begin
                    ostat_next  = wabort_reg ? nfes_pkg::STATUS_FLASH : nfes_pkg::STATUS_OK;
                    ofault_next = wfault_reg;
                end
                default:
                begin
                    ostat_next = nfes_pkg::STATUS_OK;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg   <= SIZE_RESET;
            check_reg  <= 1'b0;
            wleft_reg  <= '0;
            waddr_reg  <= '0;
            wabort_reg <= 1'b0;
            wfault_reg <= '0;
            clr_reg    <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            size_reg   <= size_next;
            check_reg  <= check_next;
            wleft_reg  <= wleft_next;
            waddr_reg  <= waddr_next;
            wabort_reg <= wabort_next;
            wfault_reg <= wfault_next;
            clr_reg    <= clr_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg   <= func_next;
        off_reg    <= off_next;
        len_reg    <= len_next;
        db_reg     <= db_next;
        cnt_reg    <= cnt_next;
        ostat_reg  <= ostat_next;
        obyte_reg  <= obyte_next;
        ofault_reg <= ofault_next;
        olast_reg  <= olast_next;
    end

    assign out_valid     = ovalid_reg;
    assign status        = ostat_reg;
    assign read_byte     = obyte_reg;
    assign fault_address = ofault_reg;
    assign last          = olast_reg;

endmodule

// ===== design/nor_flash_emulating_byte_store.sv =====
// Top level of the NOR-flash-like byte store: joins the controller and the
// datapath. Depends on nfes_pkg, nfes_ctrl and nfes_dpath.
//
// Items arrive on the in channel (in_valid/in_ready) as func, offset, length
// and data_byte; results leave on the out channel (out_valid/out_ready) as
// status, read_byte, fault_address and last, one beat per result. A read gives
// one beat per byte, every other request one beat with last set. A write is a
// header beat and then one data beat per byte; read and erase requests sent
// between the data beats are served at once. The cfg channel (index 0 size in
// use, index 1 flash check enable) is always ready; write it only when idle.
//
// Every item is taken in IDLE and decoded in DECODE, and a single status
// beat is loaded in RESP. A write data byte adds a check against the
// stored byte in WCHECK, an erase writes its bytes in ERASE, and a read
// passes each byte through READ (memory read) and RDATA (output load).
// Results wait in the output register, so the next item is accepted while
// the receiver stalls; a further result waits until the register frees.
//
// After rst_n is released the block sweeps all MEM_BYTES bytes of the memory
// to 0xFF, one byte per cycle, and takes no item meanwhile.
module nor_flash_emulating_byte_store #(
    parameter int MEM_BYTES = 4096,
    parameter int MAX_BURST = 64
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [nfes_pkg::FUNC_W-1:0]    func,
    input  logic [nfes_pkg::OFFSET_W-1:0]  offset,
    input  logic [nfes_pkg::LENGTH_W-1:0]  length,
    input  logic [nfes_pkg::BYTE_W-1:0]    data_byte,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [nfes_pkg::STATUS_W-1:0]  status,
    output logic [nfes_pkg::BYTE_W-1:0]    read_byte,
    output logic [nfes_pkg::OFFSET_W-1:0]  fault_address,
    output logic                           last,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [nfes_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [nfes_pkg::SIZE_W-1:0]    cfg_data
);

    nfes_pkg::cmd_t cmd;
    nfes_pkg::sts_t sts;
    logic           cfg_fire;

    // The configuration registers take a write in any cycle.
    assign cfg_ready = 1'b1;
    assign cfg_fire  = cfg_valid && cfg_ready;

    nfes_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    nfes_dpath #(
        .MEM_BYTES (MEM_BYTES),
        .MAX_BURST (MAX_BURST)
    ) u_dpath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .sts           (sts),
        .func          (func),
        .offset        (offset),
        .length        (length),
        .data_byte     (data_byte),
        .cfg_fire      (cfg_fire),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .status        (status),
        .read_byte     (read_byte),
        .fault_address (fault_address),
        .last          (last)
    );

endmodule
